// ===== hw/rtl/slp_pkg.sv =====
// Shared constants, codes and control bundles of the slot pool allocator.
package slp_pkg;

   // Default sizes of the two stores.
   localparam int SLP_MAX_SLOTS   = 256;
   localparam int SLP_MAX_WORKERS = 16;

   // Register values taken at reset, before any limit to the sizes above.
   localparam int SLP_SLOT_COUNT_RESET   = 256;
   localparam int SLP_WORKER_COUNT_RESET = 16;

   // Field widths of the channels and registers.
   localparam int SLP_SLOT_FIELD_W   = 8;
   localparam int SLP_WORKER_FIELD_W = 4;
   localparam int SLP_SLOT_CFG_W     = 9;
   localparam int SLP_WORKER_CFG_W   = 5;
   localparam int SLP_CSR_IDX_W      = 2;
   localparam int SLP_CSR_DATA_W     = 9;

   // Worker load counters saturate at their full range.
   localparam int                    SLP_LOAD_W   = 9;
   localparam logic [SLP_LOAD_W-1:0] SLP_LOAD_MAX = '1;

   // Register indexes.
   localparam logic [SLP_CSR_IDX_W-1:0] SLP_CSR_SLOT_COUNT   = 2'd0;
   localparam logic [SLP_CSR_IDX_W-1:0] SLP_CSR_WORKER_COUNT = 2'd1;

   // Request opcodes.
   localparam logic SLP_OP_ALLOC   = 1'b0;
   localparam logic SLP_OP_RELEASE = 1'b1;

   // Response status codes.
   localparam logic SLP_STATUS_OK    = 1'b0;
   localparam logic SLP_STATUS_EMPTY = 1'b1;

   // Port strobes of the free queue and slot owner memories.
   typedef struct packed {
      logic q_rd;
      logic q_wr;
      logic sw_rd;
      logic sw_wr;
   } slp_slot_ctl_type;

   // Commands to the worker load unit.
   typedef struct packed {
      logic start;
      logic clear_wr;
      logic inc_wr;
      logic dec_rd;
      logic dec_wr;
   } slp_load_ctl_type;

endpackage

// ===== hw/rtl/slp_slot_mem.sv =====
// Free queue memory and slot owner memory, each with one write and one registered read port.
module slp_slot_mem import slp_pkg::*; #(
   parameter  int MAX_SLOTS    = SLP_MAX_SLOTS,
   parameter  int WORKER_IDX_W = 4,
   localparam int SLOT_IDX_W   = $clog2(MAX_SLOTS)
) (
   input  logic                    clock,
   input  slp_slot_ctl_type        ctl,
   input  logic [SLOT_IDX_W-1:0]   q_raddr,
   input  logic [SLOT_IDX_W-1:0]   q_waddr,
   input  logic [SLOT_IDX_W-1:0]   q_wdata,
   output logic [SLOT_IDX_W-1:0]   q_rdata,
   input  logic [SLOT_IDX_W-1:0]   sw_raddr,
   input  logic [SLOT_IDX_W-1:0]   sw_waddr,
   input  logic [WORKER_IDX_W-1:0] sw_wdata,
   output logic [WORKER_IDX_W-1:0] sw_rdata
);

   logic [SLOT_IDX_W-1:0]   queue_mem [MAX_SLOTS];
   logic [WORKER_IDX_W-1:0] owner_mem [MAX_SLOTS];
   logic [SLOT_IDX_W-1:0]   q_rdata_ff;
   logic [WORKER_IDX_W-1:0] sw_rdata_ff;

   // Read data holds until the next read of the same memory.
   always_ff @(posedge clock) begin
      if (ctl.q_wr) begin
         queue_mem[q_waddr] <= q_wdata;
      end
      if (ctl.q_rd) begin
         q_rdata_ff <= queue_mem[q_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.sw_wr) begin
         owner_mem[sw_waddr] <= sw_wdata;
      end
      if (ctl.sw_rd) begin
         sw_rdata_ff <= owner_mem[sw_raddr];
      end
   end

   assign q_rdata  = q_rdata_ff;
   assign sw_rdata = sw_rdata_ff;

endmodule

// ===== hw/rtl/slp_load_scan.sv =====
// Worker load memory with a one-entry-per-cycle least-loaded scan and saturating updates.
module slp_load_scan import slp_pkg::*; #(
   parameter  int MAX_WORKERS  = SLP_MAX_WORKERS,
   localparam int WORKER_IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1,
   localparam int WRK_CNT_W    = $clog2(MAX_WORKERS + 1)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  slp_load_ctl_type        ctl,
   input  logic [WRK_CNT_W-1:0]    worker_count,
   input  logic [WORKER_IDX_W-1:0] clear_addr,
   input  logic [WORKER_IDX_W-1:0] dec_addr,
   output logic                    scan_done,
   output logic [WORKER_IDX_W-1:0] best_worker
);

   logic [SLP_LOAD_W-1:0]   load_mem [MAX_WORKERS];
   logic [SLP_LOAD_W-1:0]   rdata_ff;
   logic                    rd_en;
   logic [WORKER_IDX_W-1:0] rd_addr;
   logic                    wr_en;
   logic [WORKER_IDX_W-1:0] wr_addr;
   logic [SLP_LOAD_W-1:0]   wr_data;

   logic                    scanning_ff, scanning_in;
   logic                    done_ff, done_in;
   logic [WRK_CNT_W-1:0]    scan_idx_ff, scan_idx_in;
   logic [WRK_CNT_W-1:0]    prev_idx;
   logic [WORKER_IDX_W-1:0] best_ff, best_in;
   logic [SLP_LOAD_W-1:0]   best_load_ff, best_load_in;

   // Scan reads entry k while comparing the data of entry k-1.
   always_comb begin
      rd_en   = ctl.start || ctl.dec_rd || (scanning_ff && (scan_idx_ff < worker_count));
      rd_addr = scan_idx_ff[WORKER_IDX_W-1:0];
      if (ctl.start) begin
         rd_addr = '0;
      end else if (ctl.dec_rd) begin
         rd_addr = dec_addr;
      end
   end

   always_comb begin
      scanning_in  = scanning_ff;
      done_in      = done_ff;
      scan_idx_in  = scan_idx_ff;
      best_in      = best_ff;
      best_load_in = best_load_ff;
      prev_idx     = scan_idx_ff - WRK_CNT_W'(1);
      if (ctl.start) begin
         scanning_in = 1'b1;
         done_in     = 1'b0;
         scan_idx_in = WRK_CNT_W'(1);
      end else if (scanning_ff) begin
         // Strict less-than keeps the lowest-numbered worker on a tie.
         if ((scan_idx_ff == WRK_CNT_W'(1)) || (rdata_ff < best_load_ff)) begin
            best_in      = prev_idx[WORKER_IDX_W-1:0];
            best_load_in = rdata_ff;
         end
         if (scan_idx_ff == worker_count) begin
            scanning_in = 1'b0;
            done_in     = 1'b1;
         end else begin
            scan_idx_in = scan_idx_ff + WRK_CNT_W'(1);
         end
      end
   end

   always_comb begin
      wr_en   = ctl.clear_wr || ctl.inc_wr || ctl.dec_wr;
      wr_addr = dec_addr;
      wr_data = (rdata_ff == '0) ? rdata_ff : rdata_ff - SLP_LOAD_W'(1);
      if (ctl.clear_wr) begin
         wr_addr = clear_addr;
         wr_data = '0;
      end else if (ctl.inc_wr) begin
         wr_addr = best_ff;
         wr_data = (best_load_ff == SLP_LOAD_MAX) ? best_load_ff
                                                  : best_load_ff + SLP_LOAD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         load_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= load_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scanning_ff <= 1'b0;
         done_ff     <= 1'b0;
         scan_idx_ff <= '0;
      end else begin
         scanning_ff <= scanning_in;
         done_ff     <= done_in;
         scan_idx_ff <= scan_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_load_ff <= best_load_in;
   end

   assign scan_done   = done_ff;
   assign best_worker = best_ff;

endmodule

// ===== hw/rtl/slot_pool_least_loaded_assign.sv =====
// Top level of the slot pool allocator with least-loaded worker assignment.
//
// Usage: a request transfer on req_* either allocates a slot (opcode allocate) or
// returns one (opcode release with has_slot set). Each request produces exactly one
// response transfer on rsp_*, in request order. An allocate answers the slot taken
// from the head of the free queue and the lowest-numbered worker with the smallest
// load; with no slot free it answers status empty and zeros. A release always
// answers status ok with zeros and is ignored when the slot is out of range or the
// queue is already full.
// Flow: requests are handled one at a time. An allocate with a free slot waits for
// the scan that reads one worker load per cycle from the load memory before its
// response is ready. A release runs an owner read, a load read and a load write; a
// failed allocate or a null release goes straight to the response. A new request is
// taken once the response has moved into the output register.
// Reset and every write to a known register start a clearing pass over
// max(MAX_SLOTS, MAX_WORKERS) entries that refills the free queue in slot order and
// zeroes all owners and loads; req_stall stays high during it, csr writes are taken.
// The response sits in an output register: while rsp_stall is high it holds, and the
// block may already take the next request, finishing it once the register frees up.
module slot_pool_least_loaded_assign import slp_pkg::*; #(
   parameter int MAX_SLOTS   = SLP_MAX_SLOTS,
   parameter int MAX_WORKERS = SLP_MAX_WORKERS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic                          req_has_slot,
   input  logic [SLP_SLOT_FIELD_W-1:0]   req_release_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_status,
   output logic [SLP_SLOT_FIELD_W-1:0]   rsp_granted_slot,
   output logic [SLP_WORKER_FIELD_W-1:0] rsp_assigned_worker,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [SLP_CSR_IDX_W-1:0]      csr_index,
   input  logic [SLP_CSR_DATA_W-1:0]     csr_wdata
);

   localparam int SLOT_IDX_W   = $clog2(MAX_SLOTS);
   localparam int SLOT_CNT_W   = $clog2(MAX_SLOTS + 1);
   localparam int WORKER_IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
   localparam int WRK_CNT_W    = $clog2(MAX_WORKERS + 1);
   localparam int CLEAR_LEN    = (MAX_SLOTS > MAX_WORKERS) ? MAX_SLOTS : MAX_WORKERS;
   localparam int CLR_W        = $clog2(CLEAR_LEN);
   localparam int SLOT_RESET   = (SLP_SLOT_COUNT_RESET > MAX_SLOTS) ? MAX_SLOTS
                                                                    : SLP_SLOT_COUNT_RESET;
   localparam int WORKER_RESET = (SLP_WORKER_COUNT_RESET > MAX_WORKERS) ? MAX_WORKERS
                                                                        : SLP_WORKER_COUNT_RESET;

   typedef enum logic [6:0] {
      ST_CLEAR       = 7'b0000001,
      ST_IDLE        = 7'b0000010,
      ST_ALLOC_SCAN  = 7'b0000100,
      ST_ALLOC_WRITE = 7'b0001000,
      ST_REL_READ    = 7'b0010000,
      ST_REL_WRITE   = 7'b0100000,
      ST_DONE        = 7'b1000000
   } slp_state_type;

   slp_state_type               state_ff, state_in;
   logic [CLR_W-1:0]            clear_idx_ff, clear_idx_in;
   logic [SLOT_CNT_W-1:0]       slot_count_ff, slot_count_in;
   logic [WRK_CNT_W-1:0]        worker_count_ff, worker_count_in;
   logic [SLOT_IDX_W-1:0]       head_ff, head_in;
   logic [SLOT_IDX_W-1:0]       tail_ff, tail_in;
   logic [SLOT_CNT_W-1:0]       free_count_ff, free_count_in;
   logic [SLOT_IDX_W-1:0]       rslot_ff, rslot_in;
   logic [WORKER_IDX_W-1:0]     owner_ff, owner_in;

   // Result of the item in progress, waiting for the output register.
   logic                          res_status_ff, res_status_in;
   logic [SLP_SLOT_FIELD_W-1:0]   res_slot_ff, res_slot_in;
   logic [SLP_WORKER_FIELD_W-1:0] res_worker_ff, res_worker_in;

   // Output register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_status_ff, rsp_status_in;
   logic [SLP_SLOT_FIELD_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic [SLP_WORKER_FIELD_W-1:0] rsp_worker_ff, rsp_worker_in;

   // Memory and load unit connections.
   slp_slot_ctl_type            slot_ctl;
   logic [SLOT_IDX_W-1:0]       q_raddr, q_waddr, q_wdata, q_rdata;
   logic [SLOT_IDX_W-1:0]       sw_raddr, sw_waddr;
   logic [WORKER_IDX_W-1:0]     sw_wdata, sw_rdata;
   slp_load_ctl_type            load_ctl;
   logic [WORKER_IDX_W-1:0]     dec_addr;
   logic                        scan_done;
   logic [WORKER_IDX_W-1:0]     best_worker;

   logic                        req_accept;
   logic                        csr_accept;
   logic                        cfg_hit;
   logic                        rsp_free;
   logic                        alloc_ok;
   logic                        rel_ok;
   logic [31:0]                 rslot_wide;
   logic [SLOT_IDX_W-1:0]       rslot_idx;
   logic [31:0]                 slot_cfg_wide;
   logic [31:0]                 worker_cfg_wide;
   logic [31:0]                 slot_cfg_value;
   logic [31:0]                 worker_cfg_value;
   logic                        head_wrap;
   logic                        tail_wrap;
   logic                        clr_in_slots;
   logic                        clr_in_workers;
   logic                        clr_live;
   logic                        clr_last;
   logic [SLOT_IDX_W-1:0]       clr_slot_addr;
   logic [SLOT_IDX_W-1:0]       tail_start;
   logic [31:0]                 grant_wide;
   logic [31:0]                 worker_wide;

   slp_slot_mem #(
      .MAX_SLOTS    (MAX_SLOTS),
      .WORKER_IDX_W (WORKER_IDX_W)
   ) u_slot_mem (
      .clock    (clock),
      .ctl      (slot_ctl),
      .q_raddr  (q_raddr),
      .q_waddr  (q_waddr),
      .q_wdata  (q_wdata),
      .q_rdata  (q_rdata),
      .sw_raddr (sw_raddr),
      .sw_waddr (sw_waddr),
      .sw_wdata (sw_wdata),
      .sw_rdata (sw_rdata)
   );

   slp_load_scan #(
      .MAX_WORKERS (MAX_WORKERS)
   ) u_load_scan (
      .clock        (clock),
      .reset        (reset),
      .ctl          (load_ctl),
      .worker_count (worker_count_ff),
      .clear_addr   (clear_idx_ff[WORKER_IDX_W-1:0]),
      .dec_addr     (dec_addr),
      .scan_done    (scan_done),
      .best_worker  (best_worker)
   );

   // Handshakes. Register writes are taken in any cycle.
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;
   assign csr_accept = csr_valid && csr_ready;
   assign cfg_hit    = csr_accept && ((csr_index == SLP_CSR_SLOT_COUNT) ||
                                      (csr_index == SLP_CSR_WORKER_COUNT));
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Register values out of range are pulled to the nearest legal count; the worker count uses only the low bits.
   assign slot_cfg_wide    = 32'(csr_wdata[SLP_SLOT_CFG_W-1:0]);
   assign worker_cfg_wide  = 32'(csr_wdata[SLP_WORKER_CFG_W-1:0]);
   assign slot_cfg_value   = (slot_cfg_wide == 32'd0) ? 32'd1 :
                             (slot_cfg_wide > 32'(MAX_SLOTS)) ? 32'(MAX_SLOTS) : slot_cfg_wide;
   assign worker_cfg_value = (worker_cfg_wide == 32'd0) ? 32'd1 :
                             (worker_cfg_wide > 32'(MAX_WORKERS)) ? 32'(MAX_WORKERS)
                                                                  : worker_cfg_wide;

   // A release counts only for a slot in range while the queue has room for it.
   assign rslot_wide = 32'(req_release_slot);
   assign rslot_idx  = rslot_wide[SLOT_IDX_W-1:0];
   assign alloc_ok   = (free_count_ff != '0);
   assign rel_ok     = req_has_slot && (rslot_wide < 32'(slot_count_ff)) &&
                       (rslot_wide < 32'(MAX_SLOTS)) && (free_count_ff < slot_count_ff);

   assign head_wrap = (32'(head_ff) == 32'(MAX_SLOTS - 1));
   assign tail_wrap = (32'(tail_ff) == 32'(MAX_SLOTS - 1));

   // The clearing pass writes one entry of each memory per cycle, up to that memory's size.
   assign clr_in_slots   = (32'(clear_idx_ff) < 32'(MAX_SLOTS));
   assign clr_in_workers = (32'(clear_idx_ff) < 32'(MAX_WORKERS));
   assign clr_live       = (32'(clear_idx_ff) < 32'(slot_count_ff));
   assign clr_last       = (32'(clear_idx_ff) == 32'(CLEAR_LEN - 1));
   assign clr_slot_addr  = clear_idx_ff[SLOT_IDX_W-1:0];
   assign tail_start     = (32'(slot_count_ff) == 32'(MAX_SLOTS)) ? '0
                                                                  : slot_count_ff[SLOT_IDX_W-1:0];

   // Granted slot and worker are reported in the low bits of their fields.
   assign grant_wide  = 32'(q_rdata);
   assign worker_wide = 32'(best_worker);

   always_comb begin
      state_in        = state_ff;
      clear_idx_in    = clear_idx_ff;
      slot_count_in   = slot_count_ff;
      worker_count_in = worker_count_ff;
      head_in         = head_ff;
      tail_in         = tail_ff;
      free_count_in   = free_count_ff;
      rslot_in        = rslot_ff;
      owner_in        = owner_ff;
      res_status_in   = res_status_ff;
      res_slot_in     = res_slot_ff;
      res_worker_in   = res_worker_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_status_in   = rsp_status_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_worker_in   = rsp_worker_ff;

      slot_ctl        = '0;
      q_raddr         = head_ff;
      q_waddr         = tail_ff;
      q_wdata         = rslot_ff;
      sw_raddr        = rslot_idx;
      sw_waddr        = rslot_ff;
      sw_wdata        = '0;
      load_ctl        = '0;
      dec_addr        = owner_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            slot_ctl.q_wr     = clr_in_slots;
            slot_ctl.sw_wr    = clr_in_slots;
            q_waddr           = clr_slot_addr;
            q_wdata           = clr_live ? clr_slot_addr : '0;
            sw_waddr          = clr_slot_addr;
            load_ctl.clear_wr = clr_in_workers;
            if (clr_last) begin
               head_in       = '0;
               tail_in       = tail_start;
               free_count_in = slot_count_ff;
               state_in      = ST_IDLE;
            end else begin
               clear_idx_in = clear_idx_ff + CLR_W'(1);
            end
         end
         ST_IDLE: begin
            if (req_accept) begin
               res_status_in = SLP_STATUS_OK;
               res_slot_in   = '0;
               res_worker_in = '0;
               state_in      = ST_DONE;
               if (req_opcode == SLP_OP_ALLOC) begin
                  if (alloc_ok) begin
                     // Read the head slot and start the load scan together.
                     slot_ctl.q_rd  = 1'b1;
                     load_ctl.start = 1'b1;
                     head_in        = head_wrap ? '0 : head_ff + SLOT_IDX_W'(1);
                     free_count_in  = free_count_ff - SLOT_CNT_W'(1);
                     state_in       = ST_ALLOC_SCAN;
                  end else begin
                     res_status_in = SLP_STATUS_EMPTY;
                  end
               end else if (rel_ok) begin
                  slot_ctl.sw_rd = 1'b1;
                  rslot_in       = rslot_idx;
                  state_in       = ST_REL_READ;
               end
            end
         end
         ST_ALLOC_SCAN: begin
            if (scan_done) begin
               state_in = ST_ALLOC_WRITE;
            end
         end
         ST_ALLOC_WRITE: begin
            slot_ctl.sw_wr  = 1'b1;
            sw_waddr        = q_rdata;
            sw_wdata        = best_worker;
            load_ctl.inc_wr = 1'b1;
            res_status_in   = SLP_STATUS_OK;
            res_slot_in     = grant_wide[SLP_SLOT_FIELD_W-1:0];
            res_worker_in   = worker_wide[SLP_WORKER_FIELD_W-1:0];
            state_in        = ST_DONE;
         end
         ST_REL_READ: begin
            // Owner is known now: fetch its load, queue the slot and clear the owner.
            load_ctl.dec_rd = 1'b1;
            dec_addr        = sw_rdata;
            owner_in        = sw_rdata;
            slot_ctl.q_wr   = 1'b1;
            slot_ctl.sw_wr  = 1'b1;
            tail_in         = tail_wrap ? '0 : tail_ff + SLOT_IDX_W'(1);
            free_count_in   = free_count_ff + SLOT_CNT_W'(1);
            state_in        = ST_REL_WRITE;
         end
         ST_REL_WRITE: begin
            load_ctl.dec_wr = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_slot_in   = res_slot_ff;
               rsp_worker_in = res_worker_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            clear_idx_in = '0;
            state_in     = ST_CLEAR;
         end
      endcase

      // A register write rebuilds the whole pool with the new count.
      if (cfg_hit) begin
         if (csr_index == SLP_CSR_SLOT_COUNT) begin
            slot_count_in = slot_cfg_value[SLOT_CNT_W-1:0];
         end else begin
            worker_count_in = worker_cfg_value[WRK_CNT_W-1:0];
         end
         clear_idx_in = '0;
         state_in     = ST_CLEAR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_idx_ff    <= '0;
         slot_count_ff   <= SLOT_CNT_W'(SLOT_RESET);
         worker_count_ff <= WRK_CNT_W'(WORKER_RESET);
         head_ff         <= '0;
         tail_ff         <= '0;
         free_count_ff   <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         clear_idx_ff    <= clear_idx_in;
         slot_count_ff   <= slot_count_in;
         worker_count_ff <= worker_count_in;
         head_ff         <= head_in;
         tail_ff         <= tail_in;
         free_count_ff   <= free_count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rslot_ff      <= rslot_in;
      owner_ff      <= owner_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_worker_ff <= res_worker_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_worker_ff <= rsp_worker_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_granted_slot    = rsp_slot_ff;
   assign rsp_assigned_worker = rsp_worker_ff;

   // The free count never exceeds the pool size between requests.
   a_free_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> (free_count_ff <= slot_count_ff))
      else $error("free count above slot count");

   // An allocate against an empty pool goes straight to the response with status empty.
   a_empty_fails: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (req_opcode == SLP_OP_ALLOC) && (free_count_ff == '0) && !cfg_hit)
      |=> ((state_ff == ST_DONE) && (res_status_ff == SLP_STATUS_EMPTY)))
      else $error("empty allocate not answered as empty");

   // The scan only ever selects a worker below the configured count.
   a_worker_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ALLOC_WRITE) |-> (32'(best_worker) < 32'(worker_count_ff)))
      else $error("selected worker out of range");

   // A response appears only after an item reached its final state.
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the done state");

endmodule

// ===== verif/slot_pool_least_loaded_assign_tb.sv =====
// Self-checking testbench for the slot pool allocator with least-loaded worker assignment.
import slp_pkg::*;

typedef struct packed {
   logic                          status;
   logic [SLP_SLOT_FIELD_W-1:0]   slot;
   logic [SLP_WORKER_FIELD_W-1:0] worker;
} slot_grant_type;

class slot_pool_scoreboard;
   int unsigned slot_count;
   int unsigned worker_count;
   logic [SLP_SLOT_FIELD_W-1:0]   free_queue [SLP_MAX_SLOTS];
   logic [SLP_WORKER_FIELD_W-1:0] slot_owner [SLP_MAX_SLOTS];
   logic [SLP_LOAD_W-1:0]         worker_load [SLP_MAX_WORKERS];
   int unsigned queue_head;
   int unsigned queue_tail;
   int unsigned free_count;
   slot_grant_type expected_q [$];
   int unsigned errors;
   int unsigned checked;

   function new();
      slot_count   = clip_count(SLP_SLOT_COUNT_RESET, SLP_MAX_SLOTS);
      worker_count = clip_count(SLP_WORKER_COUNT_RESET, SLP_MAX_WORKERS);
      refill();
   endfunction

   function int unsigned clip_count(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // A write to a known register puts the whole pool back to its initial state.
   function void refill();
      for (int i = 0; i < SLP_MAX_SLOTS; i++) begin
         free_queue[i] = (i < slot_count) ? i[SLP_SLOT_FIELD_W-1:0] : '0;
         slot_owner[i] = '0;
      end
      for (int i = 0; i < SLP_MAX_WORKERS; i++) worker_load[i] = '0;
      queue_head = 0;
      queue_tail = slot_count % SLP_MAX_SLOTS;
      free_count = slot_count;
   endfunction

   function void apply_csr(logic [SLP_CSR_IDX_W-1:0] idx, logic [SLP_CSR_DATA_W-1:0] data);
      if (idx == SLP_CSR_SLOT_COUNT) begin
         slot_count = clip_count(32'(data), SLP_MAX_SLOTS);
      end else if (idx == SLP_CSR_WORKER_COUNT) begin
         worker_count = clip_count(32'(data[SLP_WORKER_CFG_W-1:0]), SLP_MAX_WORKERS);
      end else begin
         return;
      end
      refill();
   endfunction

   function slot_grant_type note_request(logic op, logic has_slot,
                                         logic [SLP_SLOT_FIELD_W-1:0] rslot);
      slot_grant_type grant;
      int unsigned s;
      int unsigned w;
      grant = '0;
      grant.status = SLP_STATUS_OK;
      if (op == SLP_OP_ALLOC) begin
         if (free_count == 0) begin
            grant.status = SLP_STATUS_EMPTY;
         end else begin
            s = 32'(free_queue[queue_head]);
            queue_head = (queue_head + 1) % SLP_MAX_SLOTS;
            free_count--;
            w = 0;
            for (int i = 1; i < worker_count; i++)
               if (worker_load[i] < worker_load[w]) w = i;
            slot_owner[s] = w[SLP_WORKER_FIELD_W-1:0];
            if (worker_load[w] != SLP_LOAD_MAX) worker_load[w]++;
            grant.slot   = s[SLP_SLOT_FIELD_W-1:0];
            grant.worker = w[SLP_WORKER_FIELD_W-1:0];
         end
      end else if (has_slot && rslot < slot_count && free_count < slot_count) begin
         w = 32'(slot_owner[rslot]);
         free_queue[queue_tail] = rslot;
         queue_tail = (queue_tail + 1) % SLP_MAX_SLOTS;
         free_count++;
         if (worker_load[w] != 0) worker_load[w]--;
         slot_owner[rslot] = '0;
      end
      expected_q = {expected_q, grant};
      return grant;
   endfunction

   function void check_response(slot_grant_type got);
      slot_grant_type want;
      if (expected_q.size() == 0) begin
         $error("unexpected response: status %0d slot %0d worker %0d",
                got.status, got.slot, got.worker);
         errors++;
         return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         errors++;
      end
      if (got.slot !== want.slot) begin
         $error("granted_slot: expected %0d, got %0d", want.slot, got.slot);
         errors++;
      end
      if (got.worker !== want.worker) begin
         $error("assigned_worker: expected %0d, got %0d", want.worker, got.worker);
         errors++;
      end
   endfunction

   function void report_leftover();
      if (expected_q.size() != 0) begin
         $error("%0d expected responses never arrived", expected_q.size());
         errors += expected_q.size();
      end
   endfunction
endclass

module slot_pool_least_loaded_assign_tb;

   // Register indexes that the block does not decode; writes to them must change nothing.
   localparam logic [SLP_CSR_IDX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [SLP_CSR_IDX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam int NUM_PHASES      = 10;
   localparam int ITEMS_PER_PHASE = 108;
   localparam int HOLD_CYCLES     = 400;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int TAIL_CYCLES     = 40;
   localparam int RUN_LIMIT       = 10_000_000;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_opcode = SLP_OP_ALLOC;
   logic                          req_has_slot = 1'b0;
   logic [SLP_SLOT_FIELD_W-1:0]   req_release_slot = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_status;
   logic [SLP_SLOT_FIELD_W-1:0]   rsp_granted_slot;
   logic [SLP_WORKER_FIELD_W-1:0] rsp_assigned_worker;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [SLP_CSR_IDX_W-1:0]      csr_index = '0;
   logic [SLP_CSR_DATA_W-1:0]     csr_wdata = '0;

   // Prediction state and the queue of responses still owed by the block.
   slot_pool_scoreboard pool = new();

   // Slots that the block has handed out and the stimulus may give back.
   logic [SLP_SLOT_FIELD_W-1:0] held_slots [$];

   // When calm is set, neither side idles. A set hold_request asks the response
   // side for one long hold-off; that process clears it once it has started.
   bit calm = 1'b0;
   bit hold_request = 1'b0;

   int unsigned n_grants;
   int unsigned n_empty;
   int unsigned n_releases;
   int unsigned n_csr_writes;
   int unsigned n_long_holds;
   int unsigned n_req_held_off;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   slot_pool_least_loaded_assign dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_has_slot        (req_has_slot),
      .req_release_slot    (req_release_slot),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_status          (rsp_status),
      .rsp_granted_slot    (rsp_granted_slot),
      .rsp_assigned_worker (rsp_assigned_worker),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   // Idle lengths: mostly short, now and then a long stretch.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 75) return $urandom_range(1, 3);
      if (r < 95) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic int request_gap();
      if (calm || $urandom_range(0, 99) < 45) return 0;
      return idle_length();
   endfunction

   // One request transfer. The task returns at the clock edge where the transfer
   // happened, with req_valid still high, so that the caller can either present
   // the next request right away or drop valid, each with a single assignment.
   task automatic send_req(input logic op, input logic has_slot,
                           input logic [SLP_SLOT_FIELD_W-1:0] rslot);
      int gap;
      slot_grant_type grant;
      gap = request_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_opcode       <= op;
      req_has_slot     <= has_slot;
      req_release_slot <= rslot;
      @(posedge clock);
      while (req_stall) begin
         n_req_held_off++;
         @(posedge clock);
      end
      grant = pool.note_request(op, has_slot, rslot);
      if (op == SLP_OP_ALLOC) begin
         if (grant.status == SLP_STATUS_OK) begin
            held_slots = {held_slots, grant.slot};
            n_grants++;
         end else begin
            n_empty++;
         end
      end else begin
         n_releases++;
      end
   endtask

   // Drops the request valid and waits until the block has answered everything,
   // which is the only time register writes are made.
   task automatic finish_phase();
      req_valid <= 1'b0;
      do @(posedge clock); while (pool.expected_q.size() != 0);
   endtask

   // Holds csr_valid until the write transfer; the caller lowers it afterwards so
   // that writes can follow each other without a gap.
   task automatic write_csr(input logic [SLP_CSR_IDX_W-1:0] idx,
                            input logic [SLP_CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      pool.apply_csr(idx, data);
      n_csr_writes++;
   endtask

   task automatic configure(input logic [SLP_CSR_DATA_W-1:0] slot_data,
                            input logic [SLP_CSR_DATA_W-1:0] worker_data);
      if ($urandom_range(0, 1)) begin
         write_csr(SLP_CSR_SLOT_COUNT, slot_data);
         write_csr(SLP_CSR_WORKER_COUNT, worker_data);
      end else begin
         write_csr(SLP_CSR_WORKER_COUNT, worker_data);
         write_csr(SLP_CSR_SLOT_COUNT, slot_data);
      end
      csr_valid <= 1'b0;
      // The pool starts over, so nothing is held any more.
      held_slots.delete();
   endtask

   // Gives back one slot that is currently held, picked at random.
   task automatic release_held();
      int idx;
      logic [SLP_SLOT_FIELD_W-1:0] s;
      idx = $urandom_range(0, held_slots.size() - 1);
      s = held_slots[idx];
      held_slots.delete(idx);
      send_req(SLP_OP_RELEASE, 1'b1, s);
   endtask

   // One random request. Most are well-formed allocate and release traffic, so
   // that the free queue wraps and worker loads spread; the rest are null
   // releases and releases of arbitrary slots, which also produce double
   // releases and out-of-range slots. Null and out-of-range releases do nothing
   // inside the block and are not counted toward the phase length.
   task automatic random_item(output bit counted);
      int r;
      logic [SLP_SLOT_FIELD_W-1:0] s;
      r = $urandom_range(0, 99);
      counted = 1'b1;
      if (r < 6) begin
         send_req(SLP_OP_RELEASE, 1'b0, 8'($urandom_range(0, 255)));
         counted = 1'b0;
      end else if (r < 12) begin
         s = 8'($urandom_range(0, 255));
         counted = (s < pool.slot_count);
         send_req(SLP_OP_RELEASE, 1'b1, s);
      end else if (held_slots.size() == 0 || (pool.free_count > 0 && r < 60)
                   || (pool.free_count == 0 && r < 22)) begin
         send_req(SLP_OP_ALLOC, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      end else begin
         release_held();
      end
   endtask

   // Response side: checks every response transfer and drives rsp_stall. It
   // stalls at random, takes one long hold-off when asked, and stays open
   // during calm stretches.
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left  = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            pool.check_response('{rsp_status, rsp_granted_slot, rsp_assigned_worker});
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (hold_request) begin
            // Long hold-off: the request side keeps offering, so the block fills
            // its response register and then stalls its own input.
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            n_long_holds++;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (!calm && $urandom_range(0, 99) < 18) begin
            stall_left = idle_length() - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Stimulus, configuration and the end of the run.
   initial begin
      logic [SLP_CSR_DATA_W-1:0] phase_slots [NUM_PHASES];
      logic [SLP_CSR_DATA_W-1:0] phase_workers [NUM_PHASES];
      int  done;
      bit  counted;
      int  waited;
      phase_slots   = '{9'd256, 9'd3, 9'd16, 9'd1, 9'h1FF, 9'd8, 9'd0, 9'd2, 9'd0, 9'd255};
      phase_workers = '{9'd16, 9'd16, 9'd3, 9'd1, 9'h1E1, 9'd5, 9'd0, 9'd9, 9'd0, 9'd16};
      // Two phases take random register values, raw bits included; one of them
      // keeps the pool small so that it runs empty often.
      phase_slots[6]   = 9'($urandom_range(0, 511));
      phase_workers[6] = 9'($urandom_range(0, 511));
      phase_slots[8]   = 9'($urandom_range(0, 24));
      phase_workers[8] = 9'($urandom_range(0, 511));

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Default sizes: the first grants go to workers in order, a null release
      // does nothing, and releasing a slot that still sits in the queue puts it
      // in a second time and lowers worker 0's load.
      send_req(SLP_OP_ALLOC, 1'b1, 8'hFF);
      send_req(SLP_OP_ALLOC, 1'b0, 8'h00);
      send_req(SLP_OP_RELEASE, 1'b0, 8'h00);
      send_req(SLP_OP_RELEASE, 1'b1, 8'd1);
      send_req(SLP_OP_RELEASE, 1'b1, 8'hFF);
      finish_phase();

      // Zero in both registers is taken as one; the worker value only counts in
      // its low bits. A release into a full queue is ignored, the second
      // allocate finds the pool empty, and a slot past the count is ignored.
      configure(9'd0, 9'h020);
      send_req(SLP_OP_RELEASE, 1'b1, 8'd0);
      send_req(SLP_OP_ALLOC, 1'b0, 8'd0);
      send_req(SLP_OP_ALLOC, 1'b1, 8'h55);
      send_req(SLP_OP_RELEASE, 1'b1, 8'd200);
      send_req(SLP_OP_RELEASE, 1'b1, 8'd0);
      send_req(SLP_OP_ALLOC, 1'b0, 8'hAA);
      finish_phase();

      // Writes to undecoded indexes must leave the pool alone: it stays empty.
      write_csr(CSR_SPARE_A, 9'h1FF);
      write_csr(CSR_SPARE_B, 9'h000);
      csr_valid <= 1'b0;
      send_req(SLP_OP_ALLOC, 1'b0, 8'd0);
      finish_phase();

      // Values above the limits are clipped to them. After ten grants, worker 3
      // gets its slot back and, tied with the idle workers, wins the next one as
      // the lowest-numbered least-loaded worker.
      configure(9'h1FF, 9'd31);
      repeat (10) send_req(SLP_OP_ALLOC, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      send_req(SLP_OP_RELEASE, 1'b1, 8'd3);
      send_req(SLP_OP_ALLOC, 1'b0, 8'd0);
      finish_phase();

      for (int p = 0; p < NUM_PHASES; p++) begin
         calm = ($urandom_range(0, 3) == 0);
         configure(phase_slots[p], phase_workers[p]);
         if (p == 0) hold_request = 1'b1;
         done = 0;
         while (done < ITEMS_PER_PHASE) begin
            random_item(counted);
            done += int'(counted);
         end
         finish_phase();
      end

      calm = 1'b0;
      waited = 0;
      while (pool.expected_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      pool.report_leftover();

      $display("Run covered %0d grants, %0d empty-pool refusals, %0d releases, %0d %s",
               n_grants, n_empty, n_releases, n_csr_writes, "register writes.");
      $display("Checked %0d responses; %0d long receiver hold-offs; %s %0d cycles.",
               pool.checked, n_long_holds, "request side held off", n_req_held_off);
      if (pool.errors == 0) begin
         $display("PASS slot_pool_least_loaded_assign");
      end else begin
         $display("FAIL slot_pool_least_loaded_assign");
      end
      $finish;
   end

   // Watchdog: a hung handshake ends the run here.
   initial begin
      #(RUN_LIMIT);
      $display("FAIL slot_pool_least_loaded_assign");
      $finish;
   end

endmodule
